// File: src/mct_pkg.sv
// shared types, constants and helper functions of the mip chain layout unit
package mct_pkg;

    localparam int MAX_LEVELS_DEF  = 8;
    localparam int DIM_LOG_DEF     = 10;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int W_DIM   = 11;
    localparam int W_FMT   = 3;
    localparam int W_LVL   = 4;
    localparam int W_ADDR  = 23;
    localparam int W_PITCH = 13;
    localparam int W_PROD  = W_PITCH + W_DIM;
    localparam int W_SUM   = W_PROD + 1;
    localparam int W_MASK  = 4;
    localparam int W_CNT   = 5;
    localparam int W_LIM   = 16;
    localparam int W_CFG   = 16;
    localparam int W_CIDX  = 2;

    localparam logic [W_ADDR-1:0]  ADDR_MAX       = 23'h7FFFFF;
    localparam logic [W_PITCH-1:0] PITCH_MIN      = 13'd8;
    localparam logic [W_LIM-1:0]   TMEM_LIMIT_RST = 16'h1000;

    typedef enum logic [1:0] {
        ST_BUILD  = 2'd0,
        ST_DONE   = 2'd1,
        ST_BROKEN = 2'd2
    } t_status;

    typedef enum logic [W_CIDX-1:0] {
        CFG_MIPMAP = 2'd0,
        CFG_WRAP_S = 2'd1,
        CFG_WRAP_T = 2'd2,
        CFG_LIMIT  = 2'd3
    } t_cfg_idx;

    typedef enum logic [W_FMT-1:0] {
        FMT_RGB5A1 = 3'd0,
        FMT_RGBA8  = 3'd1,
        FMT_LA44   = 3'd2,
        FMT_LA88   = 3'd3,
        FMT_LUM8   = 3'd4,
        FMT_INT8   = 3'd5
    } t_format;

    typedef struct packed {
        logic                accept;
        logic                base;
        logic [W_LVL-1:0]    level;
        logic [W_PITCH-1:0]  pitch;
        logic [W_PROD-1:0]   product;
        logic [W_MASK-1:0]   mask_s;
        logic [W_MASK-1:0]   mask_t;
        logic [W_MASK-1:0]   shift_s;
        logic [W_MASK-1:0]   shift_t;
        t_status             status;
        logic [W_CNT-1:0]    count;
    } t_desc;

    // log2 of bytes per texel
    function automatic logic [1:0] texel_shift(input logic [W_FMT-1:0] fmt);
        logic [1:0] sh;
        case (fmt)
            FMT_RGBA8:            sh = 2'd2;
            FMT_RGB5A1, FMT_LA88: sh = 2'd1;
            default:              sh = 2'd0;
        endcase
        return sh;
    endfunction

    function automatic logic [W_MASK-1:0] log2_floor(input logic [W_DIM-1:0] v);
        logic [W_MASK-1:0] r;
        r = '0;
        for (int i = 1; i < W_DIM; i++) begin
            if (v[i]) begin
                r = W_MASK'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: src/mct_front.sv
// front stage: chain check, level bookkeeping and tile descriptor fields
module mct_front #(
    parameter int MAX_LEVELS = mct_pkg::MAX_LEVELS_DEF,
    parameter int DIM_LOG    = mct_pkg::DIM_LOG_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [mct_pkg::W_DIM-1:0]    i_width,
    input  logic [mct_pkg::W_DIM-1:0]    i_height,
    input  logic [mct_pkg::W_FMT-1:0]    i_format,
    input  logic                         i_base,
    input  logic                         i_mipmap,
    input  logic                         i_wrap_s,
    input  logic                         i_wrap_t,
    output mct_pkg::t_desc               o_desc
);

    localparam logic [12:0] DIM_MAX = 13'(1) << DIM_LOG;
    localparam logic [4:0]  MAX_LV  = 5'(MAX_LEVELS);

    logic [mct_pkg::W_DIM-1:0]  r_ew, n_ew;
    logic [mct_pkg::W_DIM-1:0]  r_eh, n_eh;
    logic [mct_pkg::W_FMT-1:0]  r_fmt, n_fmt;
    logic [mct_pkg::W_LVL-1:0]  r_li, n_li;
    logic [mct_pkg::W_MASK-1:0] r_bwl, n_bwl;
    logic [mct_pkg::W_MASK-1:0] r_bhl, n_bhl;
    mct_pkg::t_status           r_st, n_st;

    logic [mct_pkg::W_LVL-1:0]   cur_li;
    logic                        accept;
    logic [mct_pkg::W_PITCH-1:0] pitch_raw;
    logic [mct_pkg::W_PITCH-1:0] pitch;
    logic [mct_pkg::W_MASK-1:0]  wl;
    logic [mct_pkg::W_MASK-1:0]  hl;

    always_comb begin
        n_ew   = r_ew;
        n_eh   = r_eh;
        n_fmt  = r_fmt;
        n_bwl  = r_bwl;
        n_bhl  = r_bhl;
        n_st   = r_st;
        cur_li = r_li;
        accept = 1'b0;

        if (i_base) begin
            cur_li = '0;
            if (i_width == '0 || i_height == '0 || {2'b00, i_width} > DIM_MAX
                || {2'b00, i_height} > DIM_MAX || i_format > mct_pkg::FMT_INT8) begin
                n_st = mct_pkg::ST_BROKEN;
            end else begin
                n_st  = mct_pkg::ST_BUILD;
                n_ew  = i_width;
                n_eh  = i_height;
                n_fmt = i_format;
                n_bwl = mct_pkg::log2_floor(i_width);
                n_bhl = mct_pkg::log2_floor(i_height);
            end
        end

        if (n_st == mct_pkg::ST_BUILD) begin
            if (i_width != n_ew || i_height != n_eh || i_format != n_fmt
                || {1'b0, cur_li} >= MAX_LV) begin
                n_st = mct_pkg::ST_BROKEN;
            end else if (!i_mipmap || (i_width == 11'd1 && i_height == 11'd1)) begin
                accept = 1'b1;
                n_st   = mct_pkg::ST_DONE;
            end else if ((i_width > 11'd1 && i_width[0]) || (i_height > 11'd1 && i_height[0])
                         || ({1'b0, cur_li} + 5'd1) >= MAX_LV) begin
                n_st = mct_pkg::ST_BROKEN;
            end else begin
                accept = 1'b1;
                if (i_width > 11'd1) begin
                    n_ew = i_width >> 1;
                end
                if (i_height > 11'd1) begin
                    n_eh = i_height >> 1;
                end
            end
        end

        n_li = accept ? cur_li + 4'd1 : cur_li;
    end

    assign pitch_raw = {2'b00, i_width} << mct_pkg::texel_shift(i_format);
    assign pitch     = (pitch_raw < mct_pkg::PITCH_MIN) ? mct_pkg::PITCH_MIN : pitch_raw;
    assign wl        = (n_bwl > cur_li) ? n_bwl - cur_li : '0;
    assign hl        = (n_bhl > cur_li) ? n_bhl - cur_li : '0;

    always_comb begin
        o_desc         = '0;
        o_desc.accept  = accept;
        o_desc.base    = i_base;
        o_desc.status  = n_st;
        o_desc.count   = (n_st == mct_pkg::ST_DONE) ? {1'b0, n_li} : '0;
        if (accept) begin
            o_desc.level   = cur_li;
            o_desc.pitch   = pitch;
            o_desc.product = {11'b0, pitch} * {13'b0, i_height};
            o_desc.mask_s  = i_wrap_s ? wl : '0;
            o_desc.mask_t  = i_wrap_t ? hl : '0;
            o_desc.shift_s = n_bwl - wl;
            o_desc.shift_t = n_bhl - hl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ew  <= '0;
            r_eh  <= '0;
            r_fmt <= '0;
            r_li  <= '0;
            r_bwl <= '0;
            r_bhl <= '0;
            r_st  <= mct_pkg::ST_BROKEN;
        end else if (i_take) begin
            r_ew  <= n_ew;
            r_eh  <= n_eh;
            r_fmt <= n_fmt;
            r_li  <= n_li;
            r_bwl <= n_bwl;
            r_bhl <= n_bhl;
            r_st  <= n_st;
        end
    end

endmodule

// File: src/mct_queue.sv
// short descriptor queue between front and back
module mct_queue #(
    parameter int DEPTH = mct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mct_pkg::t_desc i_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output mct_pkg::t_desc o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mct_pkg::t_desc r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: src/mct_back.sv
// back stage: texture memory address accumulation and result register
module mct_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  mct_pkg::t_desc                i_desc,
    output logic                          o_q_pop,
    input  logic                          i_pop,
    input  logic [mct_pkg::W_LIM-1:0]     i_tmem_limit,
    output logic                          o_empty,
    output mct_pkg::t_desc                o_desc,
    output logic [mct_pkg::W_ADDR-1:0]    o_address,
    output logic                          o_fits
);

    logic                         r_out_valid;
    mct_pkg::t_desc               r_desc;
    logic [mct_pkg::W_ADDR-1:0]   r_addr;
    logic [mct_pkg::W_ADDR-1:0]   r_used;
    logic [mct_pkg::W_ADDR-1:0]   n_used;
    logic [mct_pkg::W_ADDR-1:0]   base_addr;
    logic [mct_pkg::W_SUM:0]      sum;
    logic [mct_pkg::W_SUM:0]      rounded;
    logic                         advance;

    assign advance   = i_q_valid && (!r_out_valid || i_pop);
    assign o_q_pop   = advance;
    assign base_addr = i_desc.base ? '0 : r_used;
    assign sum       = {3'b000, base_addr} + {2'b00, i_desc.product} + 26'd7;
    assign rounded   = {sum[mct_pkg::W_SUM:3], 3'b000};

    always_comb begin
        n_used = base_addr;
        if (i_desc.accept) begin
            n_used = (rounded > {3'b000, mct_pkg::ADDR_MAX}) ? mct_pkg::ADDR_MAX
                                                          : rounded[mct_pkg::W_ADDR-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_used      <= '0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_used      <= n_used;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_desc <= i_desc;
            r_addr <= i_desc.accept ? base_addr : '0;
        end
    end

    assign o_empty   = !r_out_valid;
    assign o_desc    = r_desc;
    assign o_address = r_addr;
    assign o_fits    = (r_used <= {7'b0, i_tmem_limit});

endmodule

// File: src/mipmap_chain_tmem_layout_unit.sv
// top level of the mip chain checker and texture memory layout unit
//
// input channel: one mip level per beat (width, height, format, base flag),
// taken at a clock edge with push high and full low. a beat with the base
// flag set starts a new chain and restarts the memory layout at address 0.
// result channel: one descriptor per input beat, in order, shown while empty
// is low and taken at a clock edge with pop high.
// config port: i_cfg_we writes register i_cfg_idx (0 mipmapping, 1 wrap s,
// 2 wrap t, 3 memory limit) in the same edge; write only while idle.
// a taken beat is held in the queue, then in the back stage result register, where it is visible.
// throughput: one beat per cycle while full is low; the chain check in the
// front stage and the address add in the back stage are combinational.
// a two-entry queue sits between front and back; when pop is held low the
// result register holds, the queue fills and full rises once it holds two beats.
// reset clears the chain state to broken, the layout to address 0, empties
// the queue and restores the register defaults.
module mipmap_chain_tmem_layout_unit #(
    parameter int MAX_LEVELS  = mct_pkg::MAX_LEVELS_DEF,
    parameter int DIM_LOG     = mct_pkg::DIM_LOG_DEF,
    parameter int QUEUE_DEPTH = mct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [mct_pkg::W_DIM-1:0]     i_level_width,
    input  logic [mct_pkg::W_DIM-1:0]     i_level_height,
    input  logic [mct_pkg::W_FMT-1:0]     i_pixel_format,
    input  logic                          i_base_level,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_tile_valid,
    output logic [mct_pkg::W_LVL-1:0]     o_tile_level,
    output logic [mct_pkg::W_ADDR-1:0]    o_tmem_address,
    output logic [mct_pkg::W_PITCH-1:0]   o_tmem_pitch,
    output logic [mct_pkg::W_MASK-1:0]    o_mask_s,
    output logic [mct_pkg::W_MASK-1:0]    o_mask_t,
    output logic [mct_pkg::W_MASK-1:0]    o_shift_s,
    output logic [mct_pkg::W_MASK-1:0]    o_shift_t,
    output logic [1:0]                    o_chain_status,
    output logic [mct_pkg::W_CNT-1:0]     o_level_count,
    output logic                          o_fits_tmem,
    input  logic                          i_cfg_we,
    input  logic [mct_pkg::W_CIDX-1:0]    i_cfg_idx,
    input  logic [mct_pkg::W_CFG-1:0]     i_cfg_data
);

    logic                      r_mipmap;
    logic                      r_wrap_s;
    logic                      r_wrap_t;
    logic [mct_pkg::W_LIM-1:0] r_limit;

    logic           take;
    mct_pkg::t_desc front_desc;
    mct_pkg::t_desc q_desc;
    mct_pkg::t_desc out_desc;
    logic           q_valid;
    logic           q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mipmap <= 1'b1;
            r_wrap_s <= 1'b1;
            r_wrap_t <= 1'b1;
            r_limit  <= mct_pkg::TMEM_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mct_pkg::CFG_MIPMAP: r_mipmap <= i_cfg_data[0];
                mct_pkg::CFG_WRAP_S: r_wrap_s <= i_cfg_data[0];
                mct_pkg::CFG_WRAP_T: r_wrap_t <= i_cfg_data[0];
                mct_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[mct_pkg::W_LIM-1:0];
                default: ;
            endcase
        end
    end

    assign take = push && !full;

    mct_front #(
        .MAX_LEVELS (MAX_LEVELS),
        .DIM_LOG    (DIM_LOG)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_width  (i_level_width),
        .i_height (i_level_height),
        .i_format (i_pixel_format),
        .i_base   (i_base_level),
        .i_mipmap (r_mipmap),
        .i_wrap_s (r_wrap_s),
        .i_wrap_t (r_wrap_t),
        .o_desc   (front_desc)
    );

    mct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_desc),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_desc)
    );

    mct_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_desc       (q_desc),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .i_tmem_limit (r_limit),
        .o_empty      (empty),
        .o_desc       (out_desc),
        .o_address    (o_tmem_address),
        .o_fits       (o_fits_tmem)
    );

    assign o_tile_valid   = out_desc.accept;
    assign o_tile_level   = out_desc.level;
    assign o_tmem_pitch   = out_desc.pitch;
    assign o_mask_s       = out_desc.mask_s;
    assign o_mask_t       = out_desc.mask_t;
    assign o_shift_s      = out_desc.shift_s;
    assign o_shift_t      = out_desc.shift_t;
    assign o_chain_status = out_desc.status;
    assign o_level_count  = out_desc.count;

endmodule

// File: src/mct_checker.sv
// port-level checker of the mip chain layout unit and its bind
module mct_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        empty,
    input logic                        pop,
    input logic                        o_tile_valid,
    input logic [mct_pkg::W_ADDR-1:0]  o_tmem_address,
    input logic [mct_pkg::W_PITCH-1:0] o_tmem_pitch,
    input logic [1:0]                  o_chain_status,
    input logic [mct_pkg::W_CNT-1:0]   o_level_count
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_tmem_address)))
        else $error("stalled result beat changed");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_tile_valid) |-> (o_tmem_address == '0 && o_tmem_pitch == '0))
        else $error("rejected level carries a descriptor");

    a_pitch_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_tile_valid) |-> (o_tmem_pitch >= mct_pkg::PITCH_MIN))
        else $error("tile pitch below minimum");

    a_count_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_chain_status != mct_pkg::ST_DONE) |-> (o_level_count == '0))
        else $error("level count outside a complete chain");

endmodule

bind mipmap_chain_tmem_layout_unit mct_checker u_mct_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_tile_valid   (o_tile_valid),
    .o_tmem_address (o_tmem_address),
    .o_tmem_pitch   (o_tmem_pitch),
    .o_chain_status (o_chain_status),
    .o_level_count  (o_level_count)
);
